// File: design/hld_pkg.sv
// ----------------------------------------------------------------------------
// hld_pkg: shared constants, types and table builder
// Score format, time and divider widths, pipeline payload types and the
// elaboration-time builder of the 2^-x fraction table.
// ----------------------------------------------------------------------------
package hld_pkg;

	localparam int FRACTION_BITS = 10;
	localparam int SCORE_BITS    = 16;
	localparam int SW            = SCORE_BITS + 1;
	localparam int TIME_W        = 48;
	localparam int HL_W          = 12;
	localparam int DAY_W         = 27;
	localparam int DIV_W         = DAY_W + HL_W;
	localparam int IP_BITS       = $clog2(SCORE_BITS + 2);
	localparam int QB            = FRACTION_BITS + IP_BITS;
	localparam int TOP_W         = TIME_W - IP_BITS;
	localparam int PROD_W        = 2 * SW;
	localparam int SH_W          = $clog2(SCORE_BITS + (1 << IP_BITS));
	localparam int ROM_N         = 1 << FRACTION_BITS;
	localparam int K_W           = SCORE_BITS - 3;
	localparam int RP_W          = SW + K_W;
	localparam int REG_W         = 1;
	localparam int CFG_W         = SW;
	localparam int PIPE_DEPTH    = QB + 5;
	localparam int HL_RESET      = 30;

	localparam logic [DAY_W-1:0] DAY_MS    = DAY_W'(86400000);
	localparam logic [SW-1:0]    SCORE_ONE = {1'b1, {SCORE_BITS{1'b0}}};
	localparam logic [K_W-1:0]   REINF_K   = K_W'(((64'd1 << SCORE_BITS) + 64'd5) / 64'd10);
	localparam logic [DIV_W-1:0] D_RESET   = DIV_W'(64'(DAY_MS) * 64'(HL_RESET));

	typedef enum logic [REG_W-1:0] {
		REG_HALF_LIFE = 1'b0,
		REG_THRESHOLD = 1'b1
	} hld_reg_t;

	typedef struct packed {
		logic          keep;
		logic          chk;
		logic          sat;
		logic [SW-1:0] score;
	} hld_side_t;

	typedef struct packed {
		hld_side_t        side;
		logic [DIV_W-1:0] rem;
		logic [QB-1:0]    nlo;
		logic [QB-1:0]    quo;
	} hld_div_t;

	typedef logic [SW-1:0] hld_rom_t [ROM_N];

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[125:62];
	endfunction

	function automatic logic [63:0] sqrt_q62(input logic [63:0] t);
		logic [63:0]  y;
		logic [63:0]  c;
		logic [127:0] tt;
		logic [127:0] cc;
		tt = 128'(t) << 62;
		y  = '0;
		for (int b = 62; b >= 0; b--) begin
			c  = y | (64'd1 << b);
			cc = 128'(c) * 128'(c);
			if (cc <= tt) begin
				y = c;
			end
		end
		return y;
	endfunction

	function automatic hld_rom_t build_rom();
		logic [63:0] root [FRACTION_BITS+1];
		logic [63:0] p;
		hld_rom_t    r;
		root[0] = 64'd1 << 61;
		for (int j = 1; j <= FRACTION_BITS; j++) begin
			root[j] = sqrt_q62(root[j-1]);
		end
		for (int i = 0; i < ROM_N; i++) begin
			p = 64'd1 << 62;
			for (int k = 0; k < FRACTION_BITS; k++) begin
				if (i[k]) begin
					p = mul_q62(p, root[FRACTION_BITS-k]);
				end
			end
			r[i] = SW'(((p >> (61 - SCORE_BITS)) + 64'd1) >> 1);
		end
		return r;
	endfunction

endpackage

// File: design/hld_in_if.sv
// ----------------------------------------------------------------------------
// hld_in_if: score request channel
// Valid/ready channel carrying one decay or reinforce request.
// ----------------------------------------------------------------------------
interface hld_in_if;
	import hld_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SW-1:0]     importance;
	logic [TIME_W-1:0] last_access_ms;
	logic [TIME_W-1:0] current_time_ms;

	modport source (
		output valid, opcode, importance, last_access_ms, current_time_ms,
		input  ready
	);
	modport sink (
		input  valid, opcode, importance, last_access_ms, current_time_ms,
		output ready
	);
endinterface

// File: design/hld_out_if.sv
// ----------------------------------------------------------------------------
// hld_out_if: score result channel
// Valid/ready channel carrying the updated score and the prune flag.
// ----------------------------------------------------------------------------
interface hld_out_if;
	import hld_pkg::*;

	logic          valid;
	logic          ready;
	logic [SW-1:0] new_importance;
	logic          prune;

	modport source (
		output valid, new_importance, prune,
		input  ready
	);
	modport sink (
		input  valid, new_importance, prune,
		output ready
	);
endinterface

// File: design/hld_cfg_if.sv
// ----------------------------------------------------------------------------
// hld_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hld_cfg_if;
	import hld_pkg::*;

	logic             valid;
	logic             ready;
	logic [REG_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: design/hld_prep.sv
// ----------------------------------------------------------------------------
// hld_prep: request front end
// Two stages: elapsed time, bypass and reinforce product, then reinforce
// result, quotient overflow check and divider seed.
// ----------------------------------------------------------------------------
module hld_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	hld_in_if.sink                  item,
	input  logic [hld_pkg::DIV_W-1:0] d,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hld_pkg::hld_div_t       out_data
);
	import hld_pkg::*;

	localparam int RS_W = RP_W + 1;
	localparam logic [RS_W-1:0] HALF = RS_W'(64'd1 << (SCORE_BITS - 1));

	logic              en1;
	logic              en2;
	logic [TIME_W-1:0] elapsed;
	logic              byp;
	logic [SW-1:0]     diff;
	logic [RP_W-1:0]   rprod;

	logic              vld_s1;
	logic              op_s1;
	logic [SW-1:0]     cur_s1;
	logic [TIME_W-1:0] el_s1;
	logic              byp_s1;
	logic [RP_W-1:0]   rprod_s1;

	logic [RS_W-1:0]   rsum;
	logic [RS_W-1:0]   inc;
	logic [SW:0]       sum;
	logic [SW-1:0]     reinf;
	logic [TOP_W-1:0]  top;
	hld_div_t          nxt;

	logic              vld_s2;
	hld_div_t          dat_s2;

	assign en2        = !vld_s2 || out_ready;
	assign en1        = !vld_s1 || en2;
	assign item.ready = en1;
	assign out_valid  = vld_s2;
	assign out_data   = dat_s2;

	always_comb begin
		elapsed = item.current_time_ms - item.last_access_ms;
		byp     = (d == '0) || (item.last_access_ms == '0)
			|| (item.current_time_ms <= item.last_access_ms);
		diff    = SCORE_ONE - item.importance;
		rprod   = RP_W'(diff) * RP_W'(REINF_K);
	end

	always_comb begin
		rsum  = {1'b0, rprod_s1} + HALF;
		inc   = rsum >> SCORE_BITS;
		sum   = {1'b0, cur_s1} + (SW+1)'(inc);
		if (cur_s1[SCORE_BITS] || (sum > {1'b0, SCORE_ONE})) begin
			reinf = SCORE_ONE;
		end else begin
			reinf = sum[SW-1:0];
		end
		top            = el_s1[TIME_W-1:IP_BITS];
		nxt.side.keep  = op_s1 || byp_s1;
		nxt.side.chk   = !op_s1;
		nxt.side.sat   = top >= TOP_W'(d);
		nxt.side.score = op_s1 ? reinf : cur_s1;
		nxt.rem        = top[DIV_W-1:0];
		nxt.nlo        = {el_s1[IP_BITS-1:0], {FRACTION_BITS{1'b0}}};
		nxt.quo        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= item.valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1    <= item.opcode;
			cur_s1   <= item.importance;
			el_s1    <= elapsed;
			byp_s1   <= byp;
			rprod_s1 <= rprod;
		end
		if (en2) begin
			dat_s2 <= nxt;
		end
	end
endmodule

// File: design/hld_div.sv
// ----------------------------------------------------------------------------
// hld_div: pipelined restoring divider
// One quotient bit per stage; the fraction of the half-life count and its
// integer part leave the last stage.
// ----------------------------------------------------------------------------
module hld_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hld_pkg::DIV_W-1:0] d,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hld_pkg::hld_div_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hld_pkg::hld_div_t         out_data
);
	import hld_pkg::*;

	logic [QB:0]   en;
	logic [QB-1:0] vld_s;
	hld_div_t      dat_s [QB];
	hld_div_t      src   [QB];
	hld_div_t      nxt   [QB];

	assign en[QB]    = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_s[QB-1];
	assign out_data  = dat_s[QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DIV_W:0] trial;
		logic           ge;
		logic           vld_in;

		assign en[k] = !vld_s[k] || en[k+1];

		if (k == 0) begin : g_first
			assign src[k] = in_data;
			assign vld_in = in_valid;
		end else begin : g_next
			assign src[k] = dat_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		always_comb begin
			trial      = {src[k].rem, src[k].nlo[QB-1]};
			ge         = trial >= {1'b0, d};
			nxt[k]     = src[k];
			nxt[k].rem = ge ? DIV_W'(trial - {1'b0, d}) : trial[DIV_W-1:0];
			nxt[k].nlo = src[k].nlo << 1;
			nxt[k].quo = {src[k].quo[QB-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				dat_s[k] <= nxt[k];
			end
		end
	end
endmodule

// File: design/hld_scale.sv
// ----------------------------------------------------------------------------
// hld_scale: fraction table, multiply and shift
// Table read, score multiply, then shift by the integer part, prune compare
// and output register.
// ----------------------------------------------------------------------------
module hld_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [hld_pkg::SW-1:0] thr,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hld_pkg::hld_div_t      in_data,
	hld_out_if.source              result
);
	import hld_pkg::*;

	localparam hld_rom_t ROM = build_rom();

	logic               en1;
	logic               en2;
	logic               en3;

	logic               vld_s1;
	hld_side_t          side_s1;
	logic [IP_BITS-1:0] ip_s1;
	logic [SW-1:0]      rom_s1;

	logic               vld_s2;
	hld_side_t          side_s2;
	logic [IP_BITS-1:0] ip_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic [SH_W-1:0]    sh;
	logic [PROD_W-1:0]  shifted;
	logic [SW-1:0]      res;

	logic               vld_s3;
	logic [SW-1:0]      res_s3;
	logic               prn_s3;

	assign en3      = !vld_s3 || result.ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	assign result.valid          = vld_s3;
	assign result.new_importance = res_s3;
	assign result.prune          = prn_s3;

	always_comb begin
		sh      = SH_W'(SCORE_BITS) + SH_W'(ip_s2);
		shifted = prod_s2 >> sh;
		if (side_s2.keep) begin
			res = side_s2.score;
		end else if (side_s2.sat) begin
			res = '0;
		end else begin
			res = shifted[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1 <= in_data.side;
			ip_s1   <= in_data.quo[QB-1:FRACTION_BITS];
			rom_s1  <= ROM[in_data.quo[FRACTION_BITS-1:0]];
		end
		if (en2) begin
			side_s2 <= side_s1;
			ip_s2   <= ip_s1;
			prod_s2 <= PROD_W'(side_s1.score) * PROD_W'(rom_s1);
		end
		if (en3) begin
			res_s3 <= res;
			prn_s3 <= side_s2.chk && (res < thr);
		end
	end

	a_out_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s3) |-> $past(vld_s2))
		else $error("result raised without a multiply stage entry");
endmodule

// File: design/half_life_decay_and_prune.sv
// ----------------------------------------------------------------------------
// half_life_decay_and_prune: half-life score decay, reinforce and prune flag
// Pipeline: 2 front stages, 15 divider stages, table read, multiply and
// output register, from request to result.
// Throughput: one request per cycle unless the result side stalls it.
// Reset: asynchronous, clears all valid bits; half-life returns to 30 days,
// prune threshold to zero. No clearing pass.
// ----------------------------------------------------------------------------
module half_life_decay_and_prune (
	input  logic      clk,
	input  logic      arst_n,
	hld_in_if.sink    item,
	hld_out_if.source result,
	hld_cfg_if.sink   cfg
);
	import hld_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [DIV_W-1:0] d_q;
	logic [SW-1:0]    thr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             prep_v;
	logic             prep_r;
	hld_div_t         prep_d;
	logic             div_v;
	logic             div_r;
	hld_div_t         div_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= D_RESET;
			thr_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HALF_LIFE: d_q   <= DIV_W'(DIV_W'(DAY_MS) * DIV_W'(cfg.data[HL_W-1:0]));
				REG_THRESHOLD: thr_q <= cfg.data[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({item.valid && item.ready, result.valid && result.ready})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	hld_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.d         (d_q),
		.out_valid (prep_v),
		.out_ready (prep_r),
		.out_data  (prep_d)
	);

	hld_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.d         (d_q),
		.in_valid  (prep_v),
		.in_ready  (prep_r),
		.in_data   (prep_d),
		.out_valid (div_v),
		.out_ready (div_r),
		.out_data  (div_d)
	);

	hld_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr_q),
		.in_valid (div_v),
		.in_ready (div_r),
		.in_data  (div_d),
		.result   (result)
	);

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_empty_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !result.valid)
		else $error("result offered with no request in flight");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> item.ready)
		else $error("empty pipeline refuses a request");
endmodule

// File: tb/half_life_decay_and_prune_tb.sv
// ----------------------------------------------------------------------------
// half_life_decay_and_prune_tb: self-checking bench for score decay and prune
// Drives decay and reinforce requests in random bursts, stalls the result
// side on changing patterns, predicts each result from its own fraction
// table and register copy, and compares results in order.
// ----------------------------------------------------------------------------
module half_life_decay_and_prune_tb;
	import hld_pkg::*;

	localparam logic OP_DECAY     = 1'b0;
	localparam logic OP_REINFORCE = 1'b1;

	localparam logic [63:0] TIME_MAX   = (64'd1 << TIME_W) - 64'd1;
	localparam logic [63:0] HALF_30    = 64'd2592000000;
	localparam logic [63:0] BOOST_K    = ((64'd1 << SCORE_BITS) + 64'd5) / 64'd10;
	localparam int          IDLE_LIMIT = 2000;

	typedef struct {
		logic              opcode;
		logic [SW-1:0]     importance;
		logic [TIME_W-1:0] last_ms;
		logic [TIME_W-1:0] now_ms;
	} score_req_t;

	typedef struct {
		logic [SW-1:0] score;
		logic          prune;
	} score_res_t;

	logic clk;
	logic arst_n;

	hld_in_if  req_if ();
	hld_out_if res_if ();
	hld_cfg_if cfg_if ();

	half_life_decay_and_prune u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	logic [SW-1:0]   half_pow_tbl [ROM_N];
	logic [HL_W-1:0] hl_days   = HL_W'(HL_RESET);
	logic [SW-1:0]   prune_thr = '0;

	score_req_t pending_reqs [$];
	score_res_t expected_scores [$];

	logic        req_fire      = 1'b0;
	int          burst_left    = 8;
	int          gap_left      = 0;
	int          stall_tick    = 0;
	logic [15:0] stall_pat     = '1;
	int          idle_cycles   = 0;
	int          mismatch_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return 64'(wide >> 62);
	endfunction

	function automatic logic [63:0] q62_root(input logic [63:0] t);
		logic [127:0] target;
		logic [127:0] sq;
		logic [63:0]  y;
		logic [63:0]  c;
		target = {t, 62'd0};
		y      = '0;
		for (int b = 62; b >= 0; b--) begin
			c  = y | (64'd1 << b);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= target) begin
				y = c;
			end
		end
		return y;
	endfunction

	task automatic fill_half_pow;
		logic [63:0] roots [FRACTION_BITS+1];
		logic [63:0] acc;
		roots[0] = 64'd1 << 61;
		for (int j = 1; j <= FRACTION_BITS; j++) begin
			roots[j] = q62_root(roots[j-1]);
		end
		for (int i = 0; i < ROM_N; i++) begin
			acc = 64'd1 << 62;
			for (int k = 0; k < FRACTION_BITS; k++) begin
				if ((i >> k) & 1) begin
					acc = q62_product(acc, roots[FRACTION_BITS-k]);
				end
			end
			half_pow_tbl[i] = SW'(((acc >> (61 - SCORE_BITS)) + 64'd1) >> 1);
		end
	endtask

	function automatic score_res_t score_update(input score_req_t r);
		logic [63:0]              elapsed;
		logic [63:0]              quot;
		logic [63:0]              ip;
		logic [63:0]              prod;
		logic [FRACTION_BITS-1:0] frac;
		score_res_t               res;
		res.prune = 1'b0;
		if (r.opcode == OP_REINFORCE) begin
			if (r.importance >= SCORE_ONE) begin
				res.score = SCORE_ONE;
			end else begin
				prod = (((64'(SCORE_ONE) - 64'(r.importance)) * BOOST_K)
					+ (64'(SCORE_ONE) >> 1)) >> SCORE_BITS;
				prod = prod + 64'(r.importance);
				res.score = (prod > 64'(SCORE_ONE)) ? SCORE_ONE : SW'(prod);
			end
		end else begin
			if (hl_days == 0 || r.last_ms == 0 || r.now_ms <= r.last_ms) begin
				res.score = r.importance;
			end else begin
				elapsed = 64'(r.now_ms) - 64'(r.last_ms);
				quot    = (elapsed << FRACTION_BITS) / (64'(DAY_MS) * 64'(hl_days));
				ip      = quot >> FRACTION_BITS;
				frac    = quot[FRACTION_BITS-1:0];
				prod    = 64'(r.importance) * 64'(half_pow_tbl[frac]);
				if (ip >= 64'(64 - SCORE_BITS)) begin
					res.score = '0;
				end else begin
					res.score = SW'(prod >> (64'(SCORE_BITS) + ip));
				end
			end
			res.prune = (res.score < prune_thr);
		end
		return res;
	endfunction

	function automatic logic [63:0] rand48();
		return {32'($urandom), 32'($urandom)} & TIME_MAX;
	endfunction

	function automatic logic [SW-1:0] rand_score();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return SW'(1);
					2: return SCORE_ONE - 1'b1;
					3: return SCORE_ONE;
					default: return '1;
				endcase
			end
			1: return SW'($urandom_range(0, (1 << SW) - 1));
			default: return SW'($urandom_range(0, 1 << SCORE_BITS));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic push_req(input logic op, input logic [SW-1:0] imp,
			input logic [63:0] last_ms, input logic [63:0] now_ms);
		score_req_t r;
		r.opcode     = op;
		r.importance = imp;
		r.last_ms    = TIME_W'(last_ms);
		r.now_ms     = TIME_W'(now_ms);
		pending_reqs.push_back(r);
	endtask

	task automatic add_random(input int n);
		score_req_t  r;
		logic [63:0] span;
		logic [63:0] elapsed;
		logic [63:0] room;
		logic [63:0] qt;
		logic [63:0] tmp;
		int          kind;
		for (int i = 0; i < n; i++) begin
			kind         = $urandom_range(0, 99);
			r.opcode     = (kind < 35) ? OP_REINFORCE : OP_DECAY;
			r.importance = rand_score();
			r.last_ms    = TIME_W'(rand48());
			r.now_ms     = TIME_W'(rand48());
			if (kind >= 35 && kind < 45) begin
				case ($urandom_range(0, 2))
					0: r.last_ms = '0;
					1: r.now_ms = r.last_ms;
					default: begin
						if (r.now_ms > r.last_ms) begin
							tmp       = 64'(r.now_ms);
							r.now_ms  = r.last_ms;
							r.last_ms = TIME_W'(tmp);
						end
					end
				endcase
			end else if (kind >= 50) begin
				span = 64'(DAY_MS) * ((hl_days == 0) ? 64'd30 : 64'(hl_days));
				case ($urandom_range(0, 5))
					0, 1, 2: qt = 64'($urandom_range(0, 2048));
					3, 4:    qt = 64'($urandom_range(0, 20 * 1024));
					default: qt = 64'($urandom_range(0, 60 * 1024));
				endcase
				elapsed = ((qt * span) >> FRACTION_BITS) + 64'($urandom_range(0, 999));
				if (elapsed > TIME_MAX - 64'd1) begin
					elapsed = TIME_MAX - 64'd1;
				end
				room      = TIME_MAX - elapsed;
				r.last_ms = TIME_W'(64'd1 + (rand48() % room));
				r.now_ms  = TIME_W'(64'(r.last_ms) + elapsed);
			end
			pending_reqs.push_back(r);
		end
	endtask

	task automatic drain_results;
		do begin
			@(negedge clk);
		end while (pending_reqs.size() != 0 || req_if.valid || expected_scores.size() != 0);
	endtask

	task automatic write_reg(input hld_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_W-1:0] hl_val, input logic [CFG_W-1:0] thr_val);
		drain_results();
		write_reg(REG_HALF_LIFE, hl_val);
		write_reg(REG_THRESHOLD, thr_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_days   <= HL_W'(HL_RESET);
			prune_thr <= '0;
		end else if (cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.index)
				REG_HALF_LIFE: hl_days   <= cfg_if.data[HL_W-1:0];
				REG_THRESHOLD: prune_thr <= cfg_if.data;
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_fire) begin
				void'(pending_reqs.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(30, 80) : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (!(req_if.valid && !req_fire)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req_if.valid           <= 1'b1;
					req_if.opcode          <= pending_reqs[0].opcode;
					req_if.importance      <= pending_reqs[0].importance;
					req_if.last_access_ms  <= pending_reqs[0].last_ms;
					req_if.current_time_ms <= pending_reqs[0].now_ms;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (stall_tick == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = '1;
					1: stall_pat = 16'($urandom) | 16'h0001;
					2: stall_pat = 16'h8001;
					default: stall_pat = 16'($urandom) | 16'h0101;
				endcase
				stall_tick = $urandom_range(20, 80);
			end else begin
				stall_tick--;
			end
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			res_if.ready <= stall_pat[0];
		end
	end

	always @(posedge clk) begin : check_p
		score_req_t seen;
		score_res_t want;
		if (arst_n) begin
			req_fire <= req_if.valid && req_if.ready;
			if (req_if.valid && req_if.ready) begin
				seen.opcode     = req_if.opcode;
				seen.importance = req_if.importance;
				seen.last_ms    = req_if.last_access_ms;
				seen.now_ms     = req_if.current_time_ms;
				expected_scores.push_back(score_update(seen));
			end
			if (res_if.valid && res_if.ready) begin
				if (expected_scores.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_scores.pop_front();
					if (res_if.new_importance !== want.score) begin
						report_mismatch($sformatf("new_importance got %0d want %0d",
							res_if.new_importance, want.score));
					end
					if (res_if.prune !== want.prune) begin
						report_mismatch($sformatf("prune got %0b want %0b",
							res_if.prune, want.prune));
					end
				end
			end
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
					|| (cfg_if.valid && cfg_if.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		req_if.valid           = 1'b0;
		req_if.opcode          = OP_DECAY;
		req_if.importance      = '0;
		req_if.last_access_ms  = '0;
		req_if.current_time_ms = '0;
		res_if.ready           = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.index           = REG_HALF_LIFE;
		cfg_if.data            = '0;
		fill_half_pow();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 30-day half-life, no pruning
		push_req(OP_REINFORCE, '0, 0, 0);
		push_req(OP_REINFORCE, SCORE_ONE - 1'b1, TIME_MAX, 1);
		push_req(OP_REINFORCE, SCORE_ONE, 5, 9);
		push_req(OP_REINFORCE, '1, 0, 0);
		push_req(OP_REINFORCE, SW'(1), 1, 1);
		push_req(OP_DECAY, SCORE_ONE, 0, TIME_MAX);
		push_req(OP_DECAY, SW'(50000), 1000, 1000);
		push_req(OP_DECAY, SW'(50000), TIME_MAX, 1);
		push_req(OP_DECAY, SCORE_ONE, 1000, 1000 + HALF_30);
		push_req(OP_DECAY, SCORE_ONE, 1, 2);
		push_req(OP_DECAY, SCORE_ONE, 1, TIME_MAX);
		push_req(OP_DECAY, '1, 7, 7 + HALF_30);
		push_req(OP_DECAY, '0, 7, 7 + HALF_30);
		push_req(OP_DECAY, '1, 1, 1 + 47 * HALF_30);
		push_req(OP_DECAY, '1, 1, 1 + 48 * HALF_30);
		push_req(OP_DECAY, SCORE_ONE, 1, 1 + HALF_30 / 2);
		add_random(250);

		set_config(CFG_W'(1), SCORE_ONE);
		push_req(OP_DECAY, SCORE_ONE, 0, 0);
		push_req(OP_DECAY, SCORE_ONE - 1'b1, 0, 0);
		push_req(OP_DECAY, '1, 100, 100 + 64'(DAY_MS));
		push_req(OP_REINFORCE, '0, 0, 0);
		add_random(250);

		set_config(CFG_W'(4095), CFG_W'($urandom_range(0, 1 << SCORE_BITS)));
		add_random(250);

		set_config('0, CFG_W'(32768));
		add_random(200);

		set_config({CFG_W'($urandom) & ~CFG_W'(12'hFFF)} | CFG_W'($urandom_range(1, 4095)),
			'0);
		add_random(250);

		set_config(CFG_W'(1), '1);
		add_random(250);

		set_config(CFG_W'($urandom_range(1, 4095)),
			CFG_W'($urandom_range(0, 1 << SCORE_BITS)));
		add_random(250);

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
